// ===== design/rmq_pkg.sv =====
// Shared types, constants and step functions for the rotation matrix to quaternion core.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package rmq_pkg;

	localparam int DW         = 16;
	localparam int FB         = 14;
	localparam int SQ_STEPS   = 16;
	localparam int DIV1_STEPS = 18;
	localparam int DIV2_STEPS = 17;
	localparam int LANES      = 4;

	// which quaternion component comes straight from the root
	localparam logic [1:0] H_X = 2'd0;
	localparam logic [1:0] H_Y = 2'd1;
	localparam logic [1:0] H_Z = 2'd2;
	localparam logic [1:0] H_W = 2'd3;

	typedef struct packed {
		logic signed [DW-1:0] m00;
		logic signed [DW-1:0] m01;
		logic signed [DW-1:0] m02;
		logic signed [DW-1:0] m10;
		logic signed [DW-1:0] m11;
		logic signed [DW-1:0] m12;
		logic signed [DW-1:0] m20;
		logic signed [DW-1:0] m21;
		logic signed [DW-1:0] m22;
		logic signed [DW-1:0] m33;
	} mat_t;

	typedef struct packed {
		logic signed [DW-1:0] quat_x;
		logic signed [DW-1:0] quat_y;
		logic signed [DW-1:0] quat_z;
		logic signed [DW-1:0] quat_w;
		logic                 degenerate;
	} quat_t;

	// root phase: two square roots side by side (radicand and corner)
	typedef struct packed {
		logic                    bad;
		logic [1:0]              h;
		logic [LANES-1:0][16:0]  n;
		logic [31:0]             xr;
		logic [31:0]             rr;
		logic [31:0]             xm;
		logic [31:0]             rm;
	} sq_t;

	// divide phase: four restoring lanes sharing one divisor
	typedef struct packed {
		logic                    bad;
		logic [1:0]              h;
		logic [LANES-1:0]        neg;
		logic [14:0]             big;
		logic [15:0]             d;
		logic [16:0]             den;
		logic [LANES-1:0][32:0]  rem;
		logic [LANES-1:0][17:0]  q;
	} dv_t;

	// one digit of the integer square root; returns {x, res}
	function automatic logic [63:0] isq_step(input logic [31:0] x, input logic [31:0] res,
		input logic [31:0] bitv);
		logic [32:0] t;
		logic [31:0] xo;
		logic [31:0] ro;
		t = {1'b0, res} + {1'b0, bitv};
		if ({1'b0, x} >= t) begin
			xo = x - t[31:0];
			ro = (res >> 1) + bitv;
		end else begin
			xo = x;
			ro = res >> 1;
		end
		return {xo, ro};
	endfunction

	// one quotient bit of a restoring divide; returns {rem, q}
	function automatic logic [50:0] div_step(input logic [32:0] rem, input logic [16:0] den,
		input logic [4:0] step, input logic [17:0] q);
		logic [34:0] sh;
		logic [32:0] ro;
		logic [17:0] qo;
		sh = 35'(den) << step;
		ro = rem;
		qo = q;
		if ({2'b00, rem} >= sh) begin
			ro = rem - sh[32:0];
			qo = q | (18'(1) << step);
		end
		return {ro, qo};
	endfunction

endpackage
`default_nettype wire

// ===== design/rmq_front.sv =====
// Input stage: trace test, branch pick, radicands and off-diagonal pair terms.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front import rmq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_v,
	output logic      up_free,
	input  wire mat_t d_in,
	output logic      out_v,
	input  wire logic dn_free,
	output sq_t       d_out
);

	logic signed [18:0] a00, a11, a22, c33, tr, r;
	logic [1:0]         h;
	logic signed [16:0] n0, n1, n2, n3;
	logic               bad;
	sq_t                nxt;
	logic               v_q;
	sq_t                d_q;

	always_comb begin
		a00 = 19'(d_in.m00);
		a11 = 19'(d_in.m11);
		a22 = 19'(d_in.m22);
		c33 = 19'(d_in.m33);
		tr  = a00 + a11 + a22;
		h   = H_W;
		if (tr < 19'sd0) begin
			h = (d_in.m11 > d_in.m00) ? H_Y : H_X;
			if (d_in.m22 > ((h == H_Y) ? d_in.m11 : d_in.m00))
				h = H_Z;
		end
		n0 = 17'sd0;
		n1 = 17'sd0;
		n2 = 17'sd0;
		n3 = 17'sd0;
		case (h)
			H_X: begin
				r  = a00 - (a11 + a22) + c33;
				n1 = 17'(d_in.m01) + 17'(d_in.m10);
				n2 = 17'(d_in.m20) + 17'(d_in.m02);
				n3 = 17'(d_in.m21) - 17'(d_in.m12);
			end
			H_Y: begin
				r  = a11 - (a22 + a00) + c33;
				n2 = 17'(d_in.m12) + 17'(d_in.m21);
				n0 = 17'(d_in.m01) + 17'(d_in.m10);
				n3 = 17'(d_in.m02) - 17'(d_in.m20);
			end
			H_Z: begin
				r  = a22 - (a00 + a11) + c33;
				n0 = 17'(d_in.m20) + 17'(d_in.m02);
				n1 = 17'(d_in.m12) + 17'(d_in.m21);
				n3 = 17'(d_in.m10) - 17'(d_in.m01);
			end
			default: begin
				r  = tr + c33;
				n0 = 17'(d_in.m21) - 17'(d_in.m12);
				n1 = 17'(d_in.m02) - 17'(d_in.m20);
				n2 = 17'(d_in.m10) - 17'(d_in.m01);
			end
		endcase
		bad = (r <= 19'sd0) || (d_in.m33 <= 16'sd0);
		nxt.bad = bad;
		nxt.h   = h;
		nxt.n   = {n3, n2, n1, n0};
		nxt.xr  = bad ? 32'd0 : {r[17:0], 14'd0};
		nxt.rr  = 32'd0;
		nxt.xm  = (d_in.m33 <= 16'sd0) ? 32'd0 : {2'b00, d_in.m33, 14'd0};
		nxt.rm  = 32'd0;
	end

	assign up_free = !v_q || dn_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_free) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_free && in_v) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign d_out = d_q;

endmodule
`default_nettype wire

// ===== design/rmq_sqrt_cell.sv =====
// One digit cell of the square root chain, two roots in parallel.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [3:0] step,
	input  wire logic       in_v,
	output logic            up_free,
	input  wire sq_t        d_in,
	output logic            out_v,
	input  wire logic       dn_free,
	output sq_t             d_out
);

	logic [31:0] bitv;
	logic [63:0] lr, lm;
	sq_t         nxt;
	logic        v_q;
	sq_t         d_q;

	always_comb begin
		bitv   = 32'(1) << {step, 1'b0};
		lr     = isq_step(d_in.xr, d_in.rr, bitv);
		lm     = isq_step(d_in.xm, d_in.rm, bitv);
		nxt    = d_in;
		nxt.xr = lr[63:32];
		nxt.rr = lr[31:0];
		nxt.xm = lm[63:32];
		nxt.rm = lm[31:0];
	end

	assign up_free = !v_q || dn_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_free) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_free && in_v) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign d_out = d_q;

endmodule
`default_nettype wire

// ===== design/rmq_div_cell.sv =====
// One quotient-bit cell of a restoring divide chain, four lanes on one divisor.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div_cell import rmq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [4:0] step,
	input  wire logic       in_v,
	output logic            up_free,
	input  wire dv_t        d_in,
	output logic            out_v,
	input  wire logic       dn_free,
	output dv_t             d_out
);

	logic [LANES-1:0][50:0] st;
	dv_t                    nxt;
	logic                   v_q;
	dv_t                    d_q;

	always_comb begin
		nxt = d_in;
		for (int i = 0; i < LANES; i++) begin
			st[i]      = div_step(d_in.rem[i], d_in.den, step, d_in.q[i]);
			nxt.rem[i] = st[i][50:18];
			nxt.q[i]   = st[i][17:0];
		end
	end

	assign up_free = !v_q || dn_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_free) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_free && in_v) begin
			d_q <= nxt;
		end
	end

	assign out_v = v_q;
	assign d_out = d_q;

endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Top level: front stage, square root chain, two divide chains, output register.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell, rmq_div_cell.
//
//   channel | dir | handshake          | payload
//   mat     | in  | mat_valid/stall    | mat_t  (m00..m22, m33)
//   quat    | out | quat_valid/stall   | quat_t (x, y, z, w, degenerate)
//
// One matrix per cycle while quat_stall is low; the chain is the front stage,
// 16 root digits, 18 + 17 quotient bits and the output register.
// Every cell holds its own valid bit and fills a bubble ahead of it, so input
// keeps flowing while a result waits, until the whole chain is full.
// Reset clears the valid bits only; no clearing pass.
`default_nettype none
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  mat_valid,
	output logic       mat_stall,
	input  wire mat_t  mat,
	output logic       quat_valid,
	input  wire logic  quat_stall,
	output quat_t      quat
);

	sq_t  sq_d  [0:SQ_STEPS];
	logic sq_v  [0:SQ_STEPS];
	logic sq_f  [0:SQ_STEPS];
	dv_t  dv1_d [0:DIV1_STEPS];
	logic dv1_v [0:DIV1_STEPS];
	logic dv1_f [0:DIV1_STEPS];
	dv_t  dv2_d [0:DIV2_STEPS];
	logic dv2_v [0:DIV2_STEPS];
	logic dv2_f [0:DIV2_STEPS];

	logic  front_free;
	logic  out_free;
	logic  out_v_q;
	quat_t out_q;
	quat_t res;

	rmq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (mat_valid),
		.up_free (front_free),
		.d_in    (mat),
		.out_v   (sq_v[0]),
		.dn_free (sq_f[0]),
		.d_out   (sq_d[0])
	);
	assign mat_stall = !front_free;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		rmq_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (4'(SQ_STEPS - 1 - i)),
			.in_v    (sq_v[i]),
			.up_free (sq_f[i]),
			.d_in    (sq_d[i]),
			.out_v   (sq_v[i+1]),
			.dn_free (sq_f[i+1]),
			.d_out   (sq_d[i+1])
		);
	end

	// root -> first divide: den = 2s, numerator |n| * 2^F + s (rounded)
	always_comb begin
		logic [15:0] s;
		logic [16:0] mag;
		s = sq_d[SQ_STEPS].rr[15:0];
		dv1_d[0].bad = sq_d[SQ_STEPS].bad;
		dv1_d[0].h   = sq_d[SQ_STEPS].h;
		dv1_d[0].big = 15'((17'(s) + 17'd1) >> 1);
		dv1_d[0].d   = sq_d[SQ_STEPS].rm[15:0];
		dv1_d[0].den = {s, 1'b0};
		for (int i = 0; i < LANES; i++) begin
			mag = sq_d[SQ_STEPS].n[i][16] ? 17'(-sq_d[SQ_STEPS].n[i]) : sq_d[SQ_STEPS].n[i];
			dv1_d[0].q[i] = 18'd0;
			if (2'(i) == sq_d[SQ_STEPS].h) begin
				dv1_d[0].rem[i] = 33'd0;
				dv1_d[0].neg[i] = 1'b0;
			end else begin
				dv1_d[0].rem[i] = 33'({mag, 14'd0}) + 33'(s);
				dv1_d[0].neg[i] = sq_d[SQ_STEPS].n[i][16];
			end
		end
	end
	assign dv1_v[0]        = sq_v[SQ_STEPS];
	assign sq_f[SQ_STEPS]  = dv1_f[0];

	for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_dv1
		rmq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (5'(DIV1_STEPS - 1 - i)),
			.in_v    (dv1_v[i]),
			.up_free (dv1_f[i]),
			.d_in    (dv1_d[i]),
			.out_v   (dv1_v[i+1]),
			.dn_free (dv1_f[i+1]),
			.d_out   (dv1_d[i+1])
		);
	end

	// first -> second divide: quotients capped at 2^17 (always saturates later),
	// root lane gets the half root; the corner root is the divisor
	always_comb begin
		logic [17:0] qv;
		dv2_d[0]     = dv1_d[DIV1_STEPS];
		dv2_d[0].den = 17'(dv1_d[DIV1_STEPS].d);
		for (int i = 0; i < LANES; i++) begin
			if (2'(i) == dv1_d[DIV1_STEPS].h)
				qv = 18'(dv1_d[DIV1_STEPS].big);
			else if (dv1_d[DIV1_STEPS].q[i][17])
				qv = 18'h20000;
			else
				qv = dv1_d[DIV1_STEPS].q[i];
			dv2_d[0].rem[i] = 33'({qv, 14'd0}) + 33'(dv1_d[DIV1_STEPS].d >> 1);
			dv2_d[0].q[i]   = 18'd0;
		end
	end
	assign dv2_v[0]           = dv1_v[DIV1_STEPS];
	assign dv1_f[DIV1_STEPS]  = dv2_f[0];

	for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_dv2
		rmq_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (5'(DIV2_STEPS - 1 - i)),
			.in_v    (dv2_v[i]),
			.up_free (dv2_f[i]),
			.d_in    (dv2_d[i]),
			.out_v   (dv2_v[i+1]),
			.dn_free (dv2_f[i+1]),
			.d_out   (dv2_d[i+1])
		);
	end

	// sign and saturate; all components zero on a degenerate input
	always_comb begin
		logic [LANES-1:0][15:0] c;
		logic [17:0]            qq;
		for (int i = 0; i < LANES; i++) begin
			qq = dv2_d[DIV2_STEPS].q[i];
			if (dv2_d[DIV2_STEPS].bad)
				c[i] = 16'd0;
			else if (dv2_d[DIV2_STEPS].neg[i])
				c[i] = (qq >= 18'd32768) ? 16'h8000 : 16'(-qq[15:0]);
			else
				c[i] = (qq >= 18'd32768) ? 16'h7fff : qq[15:0];
		end
		res.quat_x     = c[0];
		res.quat_y     = c[1];
		res.quat_z     = c[2];
		res.quat_w     = c[3];
		res.degenerate = dv2_d[DIV2_STEPS].bad;
	end

	assign out_free          = !out_v_q || !quat_stall;
	assign dv2_f[DIV2_STEPS] = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= dv2_v[DIV2_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && dv2_v[DIV2_STEPS]) begin
			out_q <= res;
		end
	end

	assign quat_valid = out_v_q;
	assign quat       = out_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.degenerate) |->
		(out_q.quat_x == 16'sd0 && out_q.quat_y == 16'sd0 &&
		 out_q.quat_z == 16'sd0 && out_q.quat_w == 16'sd0))
		else $error("degenerate beat with nonzero components");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> (out_v_q && quat_stall))
		else $error("input stalled without a held output beat");

	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_v_q || !quat_stall) |-> !mat_stall)
		else $error("input stalled while output drains");

endmodule
`default_nettype wire
